/* rtl/bdc_pkg.sv */
// Business-day calendar package: command and status codes, calendar
// constants, holiday reset values and month tables.
// No dependencies; used by business_day_calendar_unit.
`default_nettype none

package bdc_pkg;

   // Commands
   localparam logic [2:0] CMD_CLASSIFY = 3'd0;
   localparam logic [2:0] CMD_ADD_CAL  = 3'd1;
   localparam logic [2:0] CMD_ADD_BUS  = 3'd2;
   localparam logic [2:0] CMD_DIFF_CAL = 3'd3;
   localparam logic [2:0] CMD_DIFF_BUS = 3'd4;

   // Status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_ORDER   = 2'd2;

   // Parameter defaults and fixed widths
   localparam int HOLIDAY_SLOTS_DEF   = 8;
   localparam int DAY_NUMBER_BITS_DEF = 16;
   localparam int MAX_SLOTS           = 8;
   localparam int CSR_INDEX_BITS      = 3;
   localparam int HOL_BITS            = 9;
   localparam int CIVIL_BITS          = 21;
   localparam int MUL_BITS            = 21;

   // Day count of 1 Jan 1980 from 1 Mar of year 0; day count of 31 Dec 4095 from 1 Jan 1980
   localparam logic [CIVIL_BITS-1:0] CIVIL_BASE = 21'd723120;
   localparam int                    CIVIL_TOP  = 772853;
   localparam logic [11:0]           FIRST_YEAR = 12'd1980;

   // Reciprocals for division by constants (exact over the ranges used)
   localparam logic [MUL_BITS-1:0] RCP_100 = 21'd5243;    // >> 19
   localparam logic [MUL_BITS-1:0] RCP_19  = 21'd3450;    // >> 16
   localparam logic [MUL_BITS-1:0] RCP_25  = 21'd2622;    // >> 16
   localparam logic [MUL_BITS-1:0] RCP_30  = 21'd2185;    // >> 16
   localparam logic [MUL_BITS-1:0] RCP_7S  = 21'd9363;    // >> 16
   localparam logic [MUL_BITS-1:0] RCP_7L  = 21'd1198373; // >> 23
   localparam logic [MUL_BITS-1:0] DAYS_YEAR = 21'd365;

   typedef logic [HOL_BITS-1:0] holiday_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
   } date_type;

   localparam holiday_type HOL_RESET [MAX_SLOTS] = '{
      9'd33, 9'd69, 9'd117, 9'd161, 9'd304, 9'd372, 9'd396, 9'd409
   };

   // Days in month; zero for a month code outside 1..12
   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   // Days from 1 Mar to the first of month m (March-based year)
   function automatic logic [8:0] month_offset(input logic [3:0] m);
      logic [8:0] ofs;
      unique case (m)
         4'd3:    ofs = 9'd0;
         4'd4:    ofs = 9'd31;
         4'd5:    ofs = 9'd61;
         4'd6:    ofs = 9'd92;
         4'd7:    ofs = 9'd122;
         4'd8:    ofs = 9'd153;
         4'd9:    ofs = 9'd184;
         4'd10:   ofs = 9'd214;
         4'd11:   ofs = 9'd245;
         4'd12:   ofs = 9'd275;
         4'd1:    ofs = 9'd306;
         4'd2:    ofs = 9'd337;
         default: ofs = 9'd0;
      endcase
      return ofs;
   endfunction

endpackage

`default_nettype wire

/* rtl/business_day_calendar_unit.sv */
// Business-day calendar: classify dates, add calendar or business days,
// count days between dates. One sequencer around a shared multiplier.
// Depends on bdc_pkg.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  cmd, dates a and b, day_delta
//   rsp      out        rsp_valid / rsp_stall  status, is_business, date, span
//   csr      in         csr_wr_en              csr_index, csr_wdata (holidays)
//
// Each year setup (leap flag, Easter) runs states Y0 to Y5, each date
// conversion C0 to C2, the weekday W0 and W1. Walking commands step one
// day at a time, through states EVAL and STEP, and rerun the year setup
// at each year boundary that they cross.
// Reset is synchronous and restores the default holiday table.
// req_stall is high while an item is in work; a finished result waits in
// the output register while the next item is taken.
`default_nettype none

module business_day_calendar_unit #(
   parameter int HOLIDAY_SLOTS   = bdc_pkg::HOLIDAY_SLOTS_DEF,
   parameter int DAY_NUMBER_BITS = bdc_pkg::DAY_NUMBER_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [2:0]                           req_cmd,
   input  wire logic [11:0]                          req_year_a,
   input  wire logic [3:0]                           req_month_a,
   input  wire logic [4:0]                           req_day_a,
   input  wire logic [11:0]                          req_year_b,
   input  wire logic [3:0]                           req_month_b,
   input  wire logic [4:0]                           req_day_b,
   input  wire logic signed [15:0]                   req_day_delta,
   // response channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [1:0]                                rsp_status,
   output logic                                      rsp_is_business,
   output logic [11:0]                               rsp_out_year,
   output logic [3:0]                                rsp_out_month,
   output logic [4:0]                                rsp_out_day,
   output logic [15:0]                               rsp_day_span,
   // configuration
   input  wire logic                                 csr_wr_en,
   input  wire logic [bdc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [bdc_pkg::HOL_BITS-1:0]         csr_wdata
);

   localparam int DNB     = DAY_NUMBER_BITS;
   localparam int LIM     = (1 << DNB) - 1;
   localparam int DAY_MAX = (LIM < bdc_pkg::CIVIL_TOP) ? LIM : bdc_pkg::CIVIL_TOP;
   localparam logic [DNB-1:0] POS_MAX = DNB'(DAY_MAX);
   localparam int CB = bdc_pkg::CIVIL_BITS;
   localparam int MB = bdc_pkg::MUL_BITS;

   // Sequencer states
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_Y0   = 4'd1;
   localparam logic [3:0] ST_Y1   = 4'd2;
   localparam logic [3:0] ST_Y2   = 4'd3;
   localparam logic [3:0] ST_Y3   = 4'd4;
   localparam logic [3:0] ST_Y4   = 4'd5;
   localparam logic [3:0] ST_Y5   = 4'd6;
   localparam logic [3:0] ST_C0   = 4'd7;
   localparam logic [3:0] ST_C1   = 4'd8;
   localparam logic [3:0] ST_C2   = 4'd9;
   localparam logic [3:0] ST_W0   = 4'd10;
   localparam logic [3:0] ST_W1   = 4'd11;
   localparam logic [3:0] ST_DISP = 4'd12;
   localparam logic [3:0] ST_EVAL = 4'd13;
   localparam logic [3:0] ST_STEP = 4'd14;
   localparam logic [3:0] ST_DONE = 4'd15;

   // What a year setup returns to
   localparam logic [1:0] PH_B    = 2'd0;
   localparam logic [1:0] PH_A    = 2'd1;
   localparam logic [1:0] PH_WALK = 2'd2;

   // Control registers
   logic [3:0]  state_ff, state_in;
   logic [1:0]  phase_ff, phase_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // Item and working registers
   logic [2:0]               cmd_ff, cmd_in;
   bdc_pkg::date_type        date_a_ff, date_a_in;
   logic signed [15:0]       delta_ff, delta_in;
   bdc_pkg::date_type        cur_ff, cur_in;
   logic                     leap_ff, leap_in;
   logic [5:0]               c_ff, c_in;
   logic [4:0]               g_ff, g_in;
   logic [9:0]               hraw_ff, hraw_in;
   logic [4:0]               i_ff, i_in;
   logic [12:0]              jsum_ff, jsum_in;
   logic [5:0]               emd_ff, emd_in;
   logic [CB-1:0]            p365_ff, p365_in;
   logic [2*MB-1:0]          prod_ff;
   logic [DNB-1:0]           pos_ff, pos_in;
   logic [DNB-1:0]           dn_b_ff, dn_b_in;
   logic [2:0]               wd_ff, wd_in;
   logic [15:0]              n_ff, n_in;
   logic                     dir_ff, dir_in;
   logic                     stepped_ff, stepped_in;
   logic [1:0]               res_status_ff, res_status_in;
   logic                     res_isb_ff, res_isb_in;
   logic                     res_date_ok_ff, res_date_ok_in;
   logic [15:0]              res_span_ff, res_span_in;

   // Output registers
   logic [1:0]               rsp_status_ff, rsp_status_in;
   logic                     rsp_isb_ff, rsp_isb_in;
   bdc_pkg::date_type        rsp_date_ff, rsp_date_in;
   logic [15:0]              rsp_span_ff, rsp_span_in;

   // Holiday table
   bdc_pkg::holiday_type     hol_ff [HOLIDAY_SLOTS];
   bdc_pkg::holiday_type     hol_in [HOLIDAY_SLOTS];

   // Shared multiplier operands
   logic [MB-1:0] mul_a, mul_b;

   // Year setup arithmetic
   logic [7:0]  gq;
   logic [11:0] y100;
   logic [3:0]  t25;
   logic [3:0]  hq;
   logic [4:0]  h_val;
   logic [4:0]  i_val;
   logic [9:0]  jq;
   logic [2:0]  j_val;

   // Date conversion arithmetic
   logic [11:0]   yy;
   logic [5:0]    q100;
   logic [CB-1:0] civil_full;
   logic [CB-1:0] dn_full;
   logic          date_ok;
   logic [16:0]   wq;

   // Stepping and classification
   logic [4:0]          dim_cur;
   bdc_pkg::date_type   next_fwd, next_back;
   logic                ychg_fwd, ychg_back;
   logic [6:0]          mday;
   logic                easter_hit;
   logic                hol_hit;
   logic                is_bus;
   logic signed [21:0]  r_sum;
   logic                r_bad;
   logic [CB-1:0]       diff_span;
   logic [15:0]         delta_mag;
   logic                delta_pos;
   logic [15:0]         n_eff;
   logic                step_fwd;
   logic                out_free;

   // Year setup: century, golden number, leap flag, Easter
   always_comb begin
      gq    = prod_ff[23:16];
      y100  = 12'(c_ff) * 12'd100;
      t25   = prod_ff[19:16];
      hq    = prod_ff[19:16];
      h_val = 5'(hraw_ff - 10'(hq) * 10'd30);
      if (h_val < 5'd28) begin
         i_val = h_val;
      end else if (h_val == 5'd29) begin
         i_val = 5'd28;
      end else begin
         i_val = (g_ff <= 5'd10) ? 5'd28 : 5'd27;
      end
      jq    = prod_ff[25:16];
      j_val = 3'(jsum_ff - 13'(jq) * 13'd7);
   end

   // Date to day number (civil count from 1 Mar of year 0)
   always_comb begin
      yy   = (cur_ff.month <= 4'd2) ? cur_ff.year - 12'd1 : cur_ff.year;
      q100 = prod_ff[24:19];
      civil_full = p365_ff + CB'(yy >> 2) - CB'(q100) + CB'(q100 >> 2)
                 + CB'(bdc_pkg::month_offset(cur_ff.month)) + CB'(cur_ff.day) - CB'(1);
      dn_full = civil_full - bdc_pkg::CIVIL_BASE;
      date_ok = (cur_ff.year >= bdc_pkg::FIRST_YEAR)
             && (cur_ff.month >= 4'd1) && (cur_ff.month <= 4'd12)
             && (cur_ff.day >= 5'd1) && (cur_ff.day <= dim_cur)
             && (dn_full <= CB'(DAY_MAX));
      wq = prod_ff[39:23];
   end

   // Next and previous calendar day
   always_comb begin
      dim_cur   = bdc_pkg::month_len(cur_ff.month, leap_ff);
      next_fwd  = cur_ff;
      ychg_fwd  = 1'b0;
      if (cur_ff.day >= dim_cur) begin
         next_fwd.day = 5'd1;
         if (cur_ff.month == 4'd12) begin
            next_fwd.month = 4'd1;
            next_fwd.year  = cur_ff.year + 12'd1;
            ychg_fwd       = 1'b1;
         end else begin
            next_fwd.month = cur_ff.month + 4'd1;
         end
      end else begin
         next_fwd.day = cur_ff.day + 5'd1;
      end
      next_back = cur_ff;
      ychg_back = 1'b0;
      if (cur_ff.day <= 5'd1) begin
         if (cur_ff.month <= 4'd1) begin
            next_back.month = 4'd12;
            next_back.day   = 5'd31;
            next_back.year  = cur_ff.year - 12'd1;
            ychg_back       = 1'b1;
         end else begin
            next_back.month = cur_ff.month - 4'd1;
            next_back.day   = bdc_pkg::month_len(cur_ff.month - 4'd1, leap_ff);
         end
      end else begin
         next_back.day = cur_ff.day - 5'd1;
      end
   end

   // Business-day test on the current date
   always_comb begin
      if (cur_ff.month == 4'd4) begin
         mday = 7'(cur_ff.day) + 7'd31;
      end else begin
         mday = 7'(cur_ff.day);
      end
      easter_hit = ((cur_ff.month == 4'd3) || (cur_ff.month == 4'd4))
                && ((mday + 7'd3 == 7'(emd_ff)) || (mday + 7'd2 == 7'(emd_ff)));
      hol_hit = 1'b0;
      for (int k = 0; k < HOLIDAY_SLOTS; k++) begin
         if ((hol_ff[k] != '0) && (hol_ff[k] == {cur_ff.month, cur_ff.day})) begin
            hol_hit = 1'b1;
         end
      end
      is_bus = (wd_ff < 3'd5) && !easter_hit && !hol_hit;
   end

   // Command dispatch helpers
   always_comb begin
      r_sum     = $signed(22'(pos_ff)) + 22'(delta_ff);
      r_bad     = r_sum[21] || (r_sum[20:0] > 21'(DAY_MAX));
      diff_span = CB'(dn_b_ff) - CB'(pos_ff);
      delta_mag = delta_ff[15] ? (16'd0 - $unsigned(delta_ff)) : $unsigned(delta_ff);
      delta_pos = !delta_ff[15] && (delta_ff != 16'sd0);
      n_eff     = n_ff - 16'((stepped_ff && is_bus) ? 1 : 0);
      step_fwd  = dir_ff;
      out_free  = !rsp_valid_ff || !rsp_stall;
   end

   // Shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_Y0: begin
            mul_a = MB'(cur_ff.year);
            mul_b = bdc_pkg::RCP_100;
         end
         ST_Y1: begin
            mul_a = MB'(cur_ff.year);
            mul_b = bdc_pkg::RCP_19;
         end
         ST_Y2: begin
            mul_a = MB'({c_ff, 3'b000}) + MB'(13);
            mul_b = bdc_pkg::RCP_25;
         end
         ST_Y3: begin
            mul_a = MB'(hraw_in);
            mul_b = bdc_pkg::RCP_30;
         end
         ST_Y4: begin
            mul_a = MB'(jsum_in);
            mul_b = bdc_pkg::RCP_7S;
         end
         ST_C0: begin
            mul_a = MB'(yy);
            mul_b = bdc_pkg::DAYS_YEAR;
         end
         ST_C1: begin
            mul_a = MB'(yy);
            mul_b = bdc_pkg::RCP_100;
         end
         ST_W0: begin
            mul_a = MB'(pos_ff) + MB'(1);
            mul_b = bdc_pkg::RCP_7L;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Holiday register writes
   always_comb begin
      for (int k = 0; k < HOLIDAY_SLOTS; k++) begin
         hol_in[k] = hol_ff[k];
         if (csr_wr_en && (csr_index == bdc_pkg::CSR_INDEX_BITS'(k))) begin
            hol_in[k] = csr_wdata;
         end
      end
   end

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      cmd_in         = cmd_ff;
      date_a_in      = date_a_ff;
      delta_in       = delta_ff;
      cur_in         = cur_ff;
      leap_in        = leap_ff;
      c_in           = c_ff;
      g_in           = g_ff;
      hraw_in        = hraw_ff;
      i_in           = i_ff;
      jsum_in        = jsum_ff;
      emd_in         = emd_ff;
      p365_in        = p365_ff;
      pos_in         = pos_ff;
      dn_b_in        = dn_b_ff;
      wd_in          = wd_ff;
      n_in           = n_ff;
      dir_in         = dir_ff;
      stepped_in     = stepped_ff;
      res_status_in  = res_status_ff;
      res_isb_in     = res_isb_ff;
      res_date_ok_in = res_date_ok_ff;
      res_span_in    = res_span_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_isb_in     = rsp_isb_ff;
      rsp_date_in    = rsp_date_ff;
      rsp_span_in    = rsp_span_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in         = req_cmd;
               date_a_in      = '{req_year_a, req_month_a, req_day_a};
               delta_in       = req_day_delta;
               res_status_in  = bdc_pkg::STATUS_OK;
               res_isb_in     = 1'b0;
               res_date_ok_in = 1'b0;
               res_span_in    = '0;
               if (req_cmd > bdc_pkg::CMD_DIFF_BUS) begin
                  res_status_in = bdc_pkg::STATUS_INVALID;
                  state_in      = ST_DONE;
               end else if (req_cmd >= bdc_pkg::CMD_DIFF_CAL) begin
                  cur_in   = '{req_year_b, req_month_b, req_day_b};
                  phase_in = PH_B;
                  state_in = ST_Y0;
               end else begin
                  cur_in   = '{req_year_a, req_month_a, req_day_a};
                  phase_in = PH_A;
                  state_in = ST_Y0;
               end
            end
         end
         ST_Y0: begin
            state_in = ST_Y1;
         end
         ST_Y1: begin
            c_in     = prod_ff[24:19];
            state_in = ST_Y2;
         end
         ST_Y2: begin
            g_in     = 5'(cur_ff.year - 12'(gq) * 12'd19);
            leap_in  = (cur_ff.year[1:0] == 2'd0)
                    && ((cur_ff.year != y100) || (c_ff[1:0] == 2'd0));
            state_in = ST_Y3;
         end
         ST_Y3: begin
            hraw_in  = 10'(c_ff) - 10'(c_ff >> 2) - 10'(t25)
                     + 10'(g_ff) * 10'd19 + 10'd15;
            state_in = ST_Y4;
         end
         ST_Y4: begin
            i_in     = i_val;
            jsum_in  = 13'(cur_ff.year) + 13'(cur_ff.year >> 2) + 13'(i_val) + 13'd2
                     - 13'(c_ff) + 13'(c_ff >> 2);
            state_in = ST_Y5;
         end
         ST_Y5: begin
            emd_in   = 6'(i_ff) + 6'd28 - 6'(j_val);
            state_in = (phase_ff == PH_WALK) ? ST_EVAL : ST_C0;
         end
         ST_C0: begin
            state_in = ST_C1;
         end
         ST_C1: begin
            p365_in  = prod_ff[CB-1:0];
            state_in = ST_C2;
         end
         ST_C2: begin
            if (!date_ok) begin
               res_status_in = bdc_pkg::STATUS_INVALID;
               state_in      = ST_DONE;
            end else if (phase_ff == PH_B) begin
               dn_b_in  = dn_full[DNB-1:0];
               cur_in   = date_a_ff;
               phase_in = PH_A;
               state_in = ST_Y0;
            end else begin
               pos_in   = dn_full[DNB-1:0];
               state_in = ST_W0;
            end
         end
         ST_W0: begin
            state_in = ST_W1;
         end
         ST_W1: begin
            wd_in    = 3'(MB'(pos_ff) + MB'(1) - MB'(wq) * MB'(7));
            state_in = ST_DISP;
         end
         ST_DISP: begin
            n_in       = delta_mag;
            dir_in     = (cmd_ff == bdc_pkg::CMD_DIFF_BUS) ? 1'b1 : delta_pos;
            stepped_in = 1'b0;
            phase_in   = PH_WALK;
            state_in   = ST_EVAL;
            unique case (cmd_ff)
               bdc_pkg::CMD_CLASSIFY: begin
                  res_isb_in = is_bus;
                  state_in   = ST_DONE;
               end
               bdc_pkg::CMD_ADD_CAL: begin
                  if (r_bad) begin
                     res_status_in = bdc_pkg::STATUS_ORDER;
                     state_in      = ST_DONE;
                  end
               end
               bdc_pkg::CMD_DIFF_CAL: begin
                  if (dn_b_ff < pos_ff) begin
                     res_status_in = bdc_pkg::STATUS_ORDER;
                  end else begin
                     res_span_in = (|diff_span[CB-1:16]) ? 16'hFFFF : diff_span[15:0];
                  end
                  state_in = ST_DONE;
               end
               bdc_pkg::CMD_DIFF_BUS: begin
                  if (dn_b_ff < pos_ff) begin
                     res_status_in = bdc_pkg::STATUS_ORDER;
                     state_in      = ST_DONE;
                  end
               end
               default: begin
                  state_in = ST_EVAL;
               end
            endcase
         end
         ST_EVAL: begin
            unique case (cmd_ff)
               bdc_pkg::CMD_ADD_CAL: begin
                  // move |delta| days, then roll over non-business days
                  if (n_ff != '0) begin
                     n_in     = n_ff - 16'd1;
                     state_in = ST_STEP;
                  end else if (is_bus) begin
                     res_date_ok_in = 1'b1;
                     state_in       = ST_DONE;
                  end else if (dir_ff ? (pos_ff >= POS_MAX) : (pos_ff == '0)) begin
                     res_status_in = bdc_pkg::STATUS_ORDER;
                     state_in      = ST_DONE;
                  end else begin
                     state_in = ST_STEP;
                  end
               end
               bdc_pkg::CMD_ADD_BUS: begin
                  n_in = n_eff;
                  if (n_eff == '0) begin
                     res_date_ok_in = 1'b1;
                     state_in       = ST_DONE;
                  end else if (dir_ff ? (pos_ff >= POS_MAX) : (pos_ff == '0)) begin
                     res_status_in = bdc_pkg::STATUS_ORDER;
                     state_in      = ST_DONE;
                  end else begin
                     state_in = ST_STEP;
                  end
               end
               default: begin
                  // business difference: count business days after the start
                  if (stepped_ff && is_bus && (res_span_ff != 16'hFFFF)) begin
                     res_span_in = res_span_ff + 16'd1;
                  end
                  state_in = (pos_ff == dn_b_ff) ? ST_DONE : ST_STEP;
               end
            endcase
         end
         ST_STEP: begin
            stepped_in = 1'b1;
            if (step_fwd) begin
               pos_in   = pos_ff + DNB'(1);
               cur_in   = next_fwd;
               wd_in    = (wd_ff >= 3'd6) ? 3'd0 : wd_ff + 3'd1;
               state_in = ychg_fwd ? ST_Y0 : ST_EVAL;
            end else begin
               pos_in   = pos_ff - DNB'(1);
               cur_in   = next_back;
               wd_in    = (wd_ff == 3'd0) ? 3'd6 : wd_ff - 3'd1;
               state_in = ychg_back ? ST_Y0 : ST_EVAL;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_isb_in    = res_isb_ff;
               rsp_date_in   = res_date_ok_ff ? cur_ff : '0;
               rsp_span_in   = res_span_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_A;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Holiday table
   always_ff @(posedge clock) begin
      for (int k = 0; k < HOLIDAY_SLOTS; k++) begin
         if (reset) begin
            hol_ff[k] <= bdc_pkg::HOL_RESET[k];
         end else begin
            hol_ff[k] <= hol_in[k];
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      prod_ff        <= (2*MB)'(mul_a) * (2*MB)'(mul_b);
      cmd_ff         <= cmd_in;
      date_a_ff      <= date_a_in;
      delta_ff       <= delta_in;
      cur_ff         <= cur_in;
      leap_ff        <= leap_in;
      c_ff           <= c_in;
      g_ff           <= g_in;
      hraw_ff        <= hraw_in;
      i_ff           <= i_in;
      jsum_ff        <= jsum_in;
      emd_ff         <= emd_in;
      p365_ff        <= p365_in;
      pos_ff         <= pos_in;
      dn_b_ff        <= dn_b_in;
      wd_ff          <= wd_in;
      n_ff           <= n_in;
      dir_ff         <= dir_in;
      stepped_ff     <= stepped_in;
      res_status_ff  <= res_status_in;
      res_isb_ff     <= res_isb_in;
      res_date_ok_ff <= res_date_ok_in;
      res_span_ff    <= res_span_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_isb_ff     <= rsp_isb_in;
      rsp_date_ff    <= rsp_date_in;
      rsp_span_ff    <= rsp_span_in;
   end

   // Ports
   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_is_business = rsp_isb_ff;
   assign rsp_out_year    = rsp_date_ff.year;
   assign rsp_out_month   = rsp_date_ff.month;
   assign rsp_out_day     = rsp_date_ff.day;
   assign rsp_day_span    = rsp_span_ff;

   // Checks
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != bdc_pkg::STATUS_OK)) |->
         (!rsp_isb_ff && (rsp_span_ff == '0) && (rsp_date_ff == '0)))
      else $error("error result carries nonzero fields");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result appeared outside the done state");

   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL) |-> ((pos_ff <= POS_MAX) && (wd_ff <= 3'd6)))
      else $error("walk position or weekday out of range");

   a_step_date: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) |->
         ((cur_ff.day != 5'd0) && (cur_ff.month >= 4'd1) && (cur_ff.month <= 4'd12)))
      else $error("stepping from a malformed date");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ST_IDLE))
      else $error("accepted item did not start work");

endmodule

`default_nettype wire
